// File: hdl/ljpf_pkg.sv
// Shared constants and types of the Lennard-Jones pair force block.
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

   // Default atom count and the most results one finish produces
   localparam int NUM_ATOMS_DEFAULT = 64;
   localparam int MAX_RESULTS       = 64;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int ATOM_W   = 6;
   localparam int COORD_W  = 32;
   localparam int LEN_W    = 31;
   localparam int ACC_W    = 48;
   localparam int CSR_IX_W = 3;

   // Item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_PAIR   = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IX_W-1:0] {
      CSR_CELL_X = 3'd0,
      CSR_CELL_Y = 3'd1,
      CSR_CELL_Z = 3'd2,
      CSR_CUTOFF = 3'd3,
      CSR_SHIFT  = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [LEN_W-1:0] CELL_RESET   = 31'd655360;
   localparam logic [LEN_W-1:0] CUTOFF_RESET = 31'd409600;
   localparam logic [ACC_W-1:0] SHIFT_RESET  = -48'sd273750;

   // Saturation limits of the Q24.24 accumulators
   localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;

endpackage

`default_nettype wire

// File: hdl/lennard_jones_pair_force.sv
// Top level: shifted Lennard-Jones pair force and energy accumulator.
//
// Input channel req_*: valid/ready. A load item writes one atom's position.
// A pair item takes two atom indices and runs the whole pair: two position
// reads, minimum-image reduction per axis through a shared bit-serial
// remainder unit, squared distance, cutoff test, a restoring divide for the
// reciprocal, five power products and three force products on one 32x32
// multiplier, then read-modify-write of both atoms' force entries.
// A finish item sweeps the force memory entry by entry, a read state then a
// load state, hands out one result per atom (the first MAX_RESULTS atoms at
// most) on rsp_* with the total energy and clears the entry it has read; the
// energy is cleared at the end of the sweep.
// The result sits in an output register; when the receiver stalls the sweep
// waits on it, and a new item may be taken while the last result waits.
// Reset restores the control and configuration registers and runs a clearing
// pass over the force memory, one entry a cycle, with req_ready low.
// Configuration writes via csr_* take effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_pair_force #(
   parameter int NUM_ATOMS = ljpf_pkg::NUM_ATOMS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ljpf_pkg::KIND_W-1:0]         req_kind,
   input  logic [ljpf_pkg::ATOM_W-1:0]         req_atom_a,
   input  logic [ljpf_pkg::ATOM_W-1:0]         req_atom_b,
   input  logic signed [ljpf_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [ljpf_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [ljpf_pkg::COORD_W-1:0] req_coord_z,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ljpf_pkg::ATOM_W-1:0]         rsp_atom_index,
   output logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_x,
   output logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_y,
   output logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_z,
   output logic signed [ljpf_pkg::ACC_W-1:0]   rsp_total_energy,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [ljpf_pkg::CSR_IX_W-1:0]       csr_index,
   input  logic [ljpf_pkg::ACC_W-1:0]          csr_write_data
);

   localparam int IDX_W = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;
   localparam int CW    = IDX_W + 1;
   localparam int AW    = (IDX_W + 1 > ljpf_pkg::ATOM_W) ? IDX_W + 1 : ljpf_pkg::ATOM_W;
   localparam int NOUT  = (NUM_ATOMS < ljpf_pkg::MAX_RESULTS) ? NUM_ATOMS
                                                               : ljpf_pkg::MAX_RESULTS;
   localparam int LW    = ljpf_pkg::LEN_W;
   localparam int PW    = 3 * ljpf_pkg::COORD_W;
   localparam int FW    = 3 * ljpf_pkg::ACC_W;

   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [47:0] MAX48    = ljpf_pkg::ACC_MAX;

   typedef enum logic [19:0] {
      ST_IDLE    = 20'h00001,
      ST_CLEAR   = 20'h00002,
      ST_RD_A    = 20'h00004,
      ST_RD_B    = 20'h00008,
      ST_DIFF    = 20'h00010,
      ST_MI_INIT = 20'h00020,
      ST_MI_DIV  = 20'h00040,
      ST_MI_FIN  = 20'h00080,
      ST_SQUARE  = 20'h00100,
      ST_CUT     = 20'h00200,
      ST_INV_DIV = 20'h00400,
      ST_MUL     = 20'h00800,
      ST_MUL_END = 20'h01000,
      ST_SCALE   = 20'h02000,
      ST_F_RD_A  = 20'h04000,
      ST_F_WR_A  = 20'h08000,
      ST_F_RD_B  = 20'h10000,
      ST_F_WR_B  = 20'h20000,
      ST_FIN_RD  = 20'h40000,
      ST_FIN_LD  = 20'h80000
   } state_type;

   typedef enum logic [2:0] {
      OP_I2 = 3'd0,
      OP_I3 = 3'd1,
      OP_I4 = 3'd2,
      OP_I6 = 3'd3,
      OP_I7 = 3'd4,
      OP_F  = 3'd5
   } op_type;

   // Add a signed delta to a 48-bit accumulator, saturating
   function automatic logic [47:0] sat_acc(input logic [47:0] old, input logic [48:0] delta);
      logic [49:0] sum;
      sum = {{2{old[47]}}, old} + {delta[48], delta};
      if (!sum[49] && sum[48:47] != 2'b00) begin
         return ljpf_pkg::ACC_MAX;
      end else if (sum[49] && sum[48:47] != 2'b11) begin
         return ljpf_pkg::ACC_MIN;
      end
      return sum[47:0];
   endfunction

   // Control state
   state_type      state_ff, state_in;
   logic [CW-1:0]  sweep_ff, sweep_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [1:0]     axis_ff, axis_in;
   op_type         op_ff, op_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Configuration registers and energy
   logic [LW-1:0]  cell_x_ff, cell_x_in, cell_y_ff, cell_y_in, cell_z_ff, cell_z_in;
   logic [LW-1:0]  cutoff_ff, cutoff_in;
   logic [47:0]    shift_ff, shift_in;
   logic [47:0]    energy_ff, energy_in;

   // Datapath registers
   logic [IDX_W-1:0] atom_a_ff, atom_a_in, atom_b_ff, atom_b_in;
   logic [PW-1:0]    pa_ff, pa_in;
   logic [32:0]      d_ff [3], d_in [3];
   logic [32:0]      r_ff [3], r_in [3];
   logic [48:0]      f_ff [3], f_in [3];
   logic [33:0]      num_mag_ff, num_mag_in;
   logic             num_neg_ff, num_neg_in;
   logic [32:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [63:0]      sq_ff, sq_in;
   logic [49:0]      s_ff, s_in;
   logic [63:0]      i1_ff, i1_in, i2_ff, i2_in, i3_ff, i3_in;
   logic [63:0]      i4_ff, i4_in, i6_ff, i6_in, i7_ff, i7_in;
   logic [63:0]      pp_ff, pp_in;
   logic [127:0]     acc_ff, acc_in;
   logic [63:0]      g_mag_ff, g_mag_in;
   logic             g_neg_ff, g_neg_in, g_sat_ff, g_sat_in;

   // Result register
   logic [ljpf_pkg::ATOM_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [47:0] rsp_fx_ff, rsp_fx_in, rsp_fy_ff, rsp_fy_in, rsp_fz_ff, rsp_fz_in;
   logic [47:0] rsp_e_ff, rsp_e_in;
   logic        rsp_last_ff, rsp_last_in;

   // Memories
   logic [PW-1:0]    pos_mem [NUM_ATOMS];
   logic [PW-1:0]    pos_q_ff;
   logic             pos_we, pos_re;
   logic [IDX_W-1:0] pos_wr_addr, pos_rd_addr;
   logic [PW-1:0]    pos_wr_data;
   logic [FW-1:0]    frc_mem [NUM_ATOMS];
   logic [FW-1:0]    frc_q_ff;
   logic             frc_we, frc_re;
   logic [IDX_W-1:0] frc_wr_addr, frc_rd_addr;
   logic [FW-1:0]    frc_wr_data;

   // Helpers
   logic [AW-1:0]    req_a_ext, req_b_ext;
   logic             req_a_ok, req_b_ok;
   logic [LW-1:0]    cur_len;
   logic [32:0]      cur_d, cur_r, abs_r;
   logic [34:0]      num_c;
   logic [32:0]      trial, mod_c;
   logic             trial_ge;
   logic [33:0]      rdiff_c;
   logic [63:0]      opa, opb;
   logic [31:0]      mul_a, mul_b;
   logic [127:0]     pp_sh, acc_sh;
   logic             mul_sat;
   logic [63:0]      mul_res;
   logic [47:0]      f_mag;
   logic [48:0]      f_val;
   logic [63:0]      x3, x4, x6, x7, e64, e_tot, g64;
   logic             slot_free, emit;

   assign req_a_ext = AW'(req_atom_a);
   assign req_b_ext = AW'(req_atom_b);
   assign req_a_ok  = req_a_ext < AW'(NUM_ATOMS);
   assign req_b_ok  = req_b_ext < AW'(NUM_ATOMS);
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = sweep_ff < CW'(NOUT);

   // Per-axis selects
   always_comb begin
      unique case (axis_ff)
         2'd0:    cur_len = cell_x_ff;
         2'd1:    cur_len = cell_y_ff;
         default: cur_len = cell_z_ff;
      endcase
   end
   assign cur_d = d_ff[axis_ff];
   assign cur_r = r_ff[axis_ff];
   assign abs_r = cur_r[32] ? 33'd0 - cur_r : cur_r;

   // Minimum image: 2d + L, one remainder step, floored remainder back to r
   assign num_c    = {cur_d[32], cur_d, 1'b0} + {4'b0, cur_len};
   assign trial    = (state_ff == ST_INV_DIV) ? {rem_ff[31:0], cnt_ff == 6'd48}
                                              : {rem_ff[31:0], num_mag_ff[33]};
   assign trial_ge = (state_ff == ST_INV_DIV) ? (trial >= {2'b0, s_ff[30:0]})
                                              : (trial >= {1'b0, den_ff});
   assign mod_c    = (num_neg_ff && rem_ff != 33'd0) ? {1'b0, den_ff} - rem_ff : rem_ff;
   assign rdiff_c  = {1'b0, mod_c} - {3'b0, cur_len};

   // Multiplier operands and partial product steps
   always_comb begin
      unique case (op_ff)
         OP_I2:   begin opa = i1_ff;    opb = i1_ff; end
         OP_I3:   begin opa = i2_ff;    opb = i1_ff; end
         OP_I4:   begin opa = i3_ff;    opb = i1_ff; end
         OP_I6:   begin opa = i3_ff;    opb = i3_ff; end
         OP_I7:   begin opa = i6_ff;    opb = i1_ff; end
         default: begin opa = g_mag_ff; opb = {31'b0, abs_r}; end
      endcase
   end
   assign mul_a = (cnt_ff == 6'd2 || cnt_ff == 6'd3) ? opa[63:32] : opa[31:0];
   assign mul_b = (cnt_ff == 6'd1 || cnt_ff == 6'd3) ? opb[63:32] : opb[31:0];
   always_comb begin
      unique case (cnt_ff)
         6'd1:    pp_sh = {64'b0, pp_ff};
         6'd2:    pp_sh = {32'b0, pp_ff, 32'b0};
         6'd3:    pp_sh = {32'b0, pp_ff, 32'b0};
         default: pp_sh = {pp_ff, 64'b0};
      endcase
   end
   assign acc_sh  = (op_ff == OP_F) ? (acc_ff >> 16) : (acc_ff >> 32);
   assign mul_sat = (acc_sh[127:64] != 64'd0) || opa == ALL_ONES || opb == ALL_ONES;
   assign mul_res = mul_sat ? ALL_ONES : acc_sh[63:0];

   // One force component from the scale and the separation
   assign f_mag = (mul_res > {16'b0, MAX48}) ? MAX48 : mul_res[47:0];
   always_comb begin
      if (cur_r == 33'd0) begin
         f_val = '0;
      end else if (g_sat_ff) begin
         f_val = cur_r[32] ? 49'd0 - {1'b0, MAX48} : {1'b0, MAX48};
      end else if (g_neg_ff ^ cur_r[32]) begin
         f_val = 49'd0 - {1'b0, f_mag};
      end else begin
         f_val = {1'b0, f_mag};
      end
   end

   // Pair energy and force scale
   assign x3    = {8'b0, i3_ff[63:8]};
   assign x4    = {8'b0, i4_ff[63:8]};
   assign x6    = {8'b0, i6_ff[63:8]};
   assign x7    = {8'b0, i7_ff[63:8]};
   assign e64   = (i6_ff == ALL_ONES) ? {16'b0, MAX48} : (x6 - x3) << 2;
   assign e_tot = {{16{energy_ff[47]}}, energy_ff} + e64 - {{16{shift_ff[47]}}, shift_ff};
   assign g64   = (x7 << 5) + (x7 << 4) - (x4 << 4) - (x4 << 3);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      energy_in    = energy_ff;
      atom_a_in    = atom_a_ff;
      atom_b_in    = atom_b_ff;
      pa_in        = pa_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      f_in         = f_ff;
      num_mag_in   = num_mag_ff;
      num_neg_in   = num_neg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      sq_in        = sq_ff;
      s_in         = s_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      i3_in        = i3_ff;
      i4_in        = i4_ff;
      i6_in        = i6_ff;
      i7_in        = i7_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      g_mag_in     = g_mag_ff;
      g_neg_in     = g_neg_ff;
      g_sat_in     = g_sat_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_fx_in    = rsp_fx_ff;
      rsp_fy_in    = rsp_fy_ff;
      rsp_fz_in    = rsp_fz_ff;
      rsp_e_in     = rsp_e_ff;
      rsp_last_in  = rsp_last_ff;
      pos_we       = 1'b0;
      pos_wr_addr  = req_a_ext[IDX_W-1:0];
      pos_wr_data  = {req_coord_x, req_coord_y, req_coord_z};
      pos_re       = 1'b0;
      pos_rd_addr  = atom_a_ff;
      frc_we       = 1'b0;
      frc_wr_addr  = sweep_ff[IDX_W-1:0];
      frc_wr_data  = '0;
      frc_re       = 1'b0;
      frc_rd_addr  = sweep_ff[IDX_W-1:0];

      // result register drains on transfer
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  ljpf_pkg::KIND_LOAD: begin
                     pos_we = req_a_ok;
                  end
                  ljpf_pkg::KIND_PAIR: begin
                     atom_a_in = req_a_ext[IDX_W-1:0];
                     atom_b_in = req_b_ext[IDX_W-1:0];
                     if (req_a_ok && req_b_ok) begin
                        state_in = ST_RD_A;
                     end
                  end
                  ljpf_pkg::KIND_FINISH: begin
                     sweep_in = '0;
                     state_in = ST_FIN_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            frc_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CW'(NUM_ATOMS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_A: begin
            pos_re   = 1'b1;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            pos_re      = 1'b1;
            pos_rd_addr = atom_b_ff;
            pa_in       = pos_q_ff;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            d_in[0]  = {pa_ff[95], pa_ff[95:64]} - {pos_q_ff[95], pos_q_ff[95:64]};
            d_in[1]  = {pa_ff[63], pa_ff[63:32]} - {pos_q_ff[63], pos_q_ff[63:32]};
            d_in[2]  = {pa_ff[31], pa_ff[31:0]} - {pos_q_ff[31], pos_q_ff[31:0]};
            axis_in  = 2'd0;
            state_in = ST_MI_INIT;
         end
         ST_MI_INIT: begin
            num_neg_in = num_c[34];
            num_mag_in = num_c[34] ? 34'(35'd0 - num_c) : num_c[33:0];
            den_in     = {cur_len, 1'b0};
            rem_in     = '0;
            cnt_in     = 6'd33;
            if (cur_len == '0) begin
               // no wrapping along this axis
               r_in[axis_ff] = cur_d;
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  cnt_in   = 6'd0;
                  s_in     = '0;
                  state_in = ST_SQUARE;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               state_in = ST_MI_DIV;
            end
         end
         ST_MI_DIV: begin
            rem_in     = trial_ge ? trial - {1'b0, den_ff} : trial;
            num_mag_in = num_mag_ff << 1;
            cnt_in     = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_MI_FIN;
            end
         end
         ST_MI_FIN: begin
            r_in[axis_ff] = rdiff_c[33:1];
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               cnt_in   = 6'd0;
               s_in     = '0;
               state_in = ST_SQUARE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MI_INIT;
            end
         end
         ST_SQUARE: begin
            if (cnt_ff != 6'd3) begin
               sq_in = abs_r[31:0] * abs_r[31:0];
            end
            if (cnt_ff != 6'd0) begin
               s_in = s_ff + {2'b0, sq_ff[63:16]};
            end
            if (axis_ff != 2'd2) begin
               axis_in = axis_ff + 2'd1;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = ST_CUT;
            end
         end
         ST_CUT: begin
            rem_in = '0;
            cnt_in = 6'd48;
            i1_in  = '0;
            if (s_ff == '0 || s_ff > {19'b0, cutoff_ff}) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_INV_DIV;
            end
         end
         ST_INV_DIV: begin
            // reciprocal 2^48 / s, one quotient bit a cycle
            rem_in = trial_ge ? trial - {2'b0, s_ff[30:0]} : trial;
            i1_in  = {i1_ff[62:0], trial_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               op_in    = OP_I2;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff != 6'd4) begin
               pp_in = mul_a * mul_b;
            end
            if (cnt_ff != 6'd0) begin
               acc_in = acc_ff + pp_sh;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) begin
               state_in = ST_MUL_END;
            end
         end
         ST_MUL_END: begin
            cnt_in   = 6'd0;
            acc_in   = '0;
            state_in = ST_MUL;
            unique case (op_ff)
               OP_I2: begin i2_in = mul_res; op_in = OP_I3; end
               OP_I3: begin i3_in = mul_res; op_in = OP_I4; end
               OP_I4: begin i4_in = mul_res; op_in = OP_I6; end
               OP_I6: begin i6_in = mul_res; op_in = OP_I7; end
               OP_I7: begin i7_in = mul_res; state_in = ST_SCALE; end
               default: begin
                  f_in[axis_ff] = f_val;
                  if (axis_ff == 2'd2) begin
                     state_in = ST_F_RD_A;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_SCALE: begin
            if (!e_tot[63] && e_tot[62:47] != 16'h0000) begin
               energy_in = ljpf_pkg::ACC_MAX;
            end else if (e_tot[63] && e_tot[62:47] != 16'hFFFF) begin
               energy_in = ljpf_pkg::ACC_MIN;
            end else begin
               energy_in = e_tot[47:0];
            end
            g_sat_in = (i7_ff == ALL_ONES);
            g_neg_in = g64[63];
            g_mag_in = g64[63] ? 64'd0 - g64 : g64;
            axis_in  = 2'd0;
            op_in    = OP_F;
            cnt_in   = 6'd0;
            acc_in   = '0;
            state_in = ST_MUL;
         end
         ST_F_RD_A: begin
            frc_re      = 1'b1;
            frc_rd_addr = atom_a_ff;
            state_in    = ST_F_WR_A;
         end
         ST_F_WR_A: begin
            frc_we      = 1'b1;
            frc_wr_addr = atom_a_ff;
            frc_wr_data = {sat_acc(frc_q_ff[143:96], f_ff[0]),
                           sat_acc(frc_q_ff[95:48], f_ff[1]),
                           sat_acc(frc_q_ff[47:0], f_ff[2])};
            state_in    = ST_F_RD_B;
         end
         ST_F_RD_B: begin
            frc_re      = 1'b1;
            frc_rd_addr = atom_b_ff;
            state_in    = ST_F_WR_B;
         end
         ST_F_WR_B: begin
            frc_we      = 1'b1;
            frc_wr_addr = atom_b_ff;
            frc_wr_data = {sat_acc(frc_q_ff[143:96], 49'd0 - f_ff[0]),
                           sat_acc(frc_q_ff[95:48], 49'd0 - f_ff[1]),
                           sat_acc(frc_q_ff[47:0], 49'd0 - f_ff[2])};
            state_in    = ST_IDLE;
         end
         ST_FIN_RD: begin
            frc_re   = 1'b1;
            state_in = ST_FIN_LD;
         end
         default: begin
            // ST_FIN_LD: hand out the entry read, then clear it
            if (!emit || slot_free) begin
               frc_we   = 1'b1;
               sweep_in = sweep_ff + 1'b1;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = sweep_ff[ljpf_pkg::ATOM_W-1:0];
                  rsp_fx_in    = frc_q_ff[143:96];
                  rsp_fy_in    = frc_q_ff[95:48];
                  rsp_fz_in    = frc_q_ff[47:0];
                  rsp_e_in     = energy_ff;
                  rsp_last_in  = (sweep_ff == CW'(NOUT - 1));
               end
               if (sweep_ff == CW'(NUM_ATOMS - 1)) begin
                  energy_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_FIN_RD;
               end
            end
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      cell_x_in = cell_x_ff;
      cell_y_in = cell_y_ff;
      cell_z_in = cell_z_ff;
      cutoff_in = cutoff_ff;
      shift_in  = shift_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ljpf_pkg::CSR_CELL_X: cell_x_in = csr_write_data[LW-1:0];
            ljpf_pkg::CSR_CELL_Y: cell_y_in = csr_write_data[LW-1:0];
            ljpf_pkg::CSR_CELL_Z: cell_z_in = csr_write_data[LW-1:0];
            ljpf_pkg::CSR_CUTOFF: cutoff_in = csr_write_data[LW-1:0];
            ljpf_pkg::CSR_SHIFT:  shift_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         op_ff        <= OP_I2;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         cell_x_ff    <= ljpf_pkg::CELL_RESET;
         cell_y_ff    <= ljpf_pkg::CELL_RESET;
         cell_z_ff    <= ljpf_pkg::CELL_RESET;
         cutoff_ff    <= ljpf_pkg::CUTOFF_RESET;
         shift_ff     <= ljpf_pkg::SHIFT_RESET;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         cell_x_ff    <= cell_x_in;
         cell_y_ff    <= cell_y_in;
         cell_z_ff    <= cell_z_in;
         cutoff_ff    <= cutoff_in;
         shift_ff     <= shift_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      atom_a_ff   <= atom_a_in;
      atom_b_ff   <= atom_b_in;
      pa_ff       <= pa_in;
      d_ff        <= d_in;
      r_ff        <= r_in;
      f_ff        <= f_in;
      num_mag_ff  <= num_mag_in;
      num_neg_ff  <= num_neg_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      sq_ff       <= sq_in;
      s_ff        <= s_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      i3_ff       <= i3_in;
      i4_ff       <= i4_in;
      i6_ff       <= i6_in;
      i7_ff       <= i7_in;
      pp_ff       <= pp_in;
      acc_ff      <= acc_in;
      g_mag_ff    <= g_mag_in;
      g_neg_ff    <= g_neg_in;
      g_sat_ff    <= g_sat_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_fx_ff   <= rsp_fx_in;
      rsp_fy_ff   <= rsp_fy_in;
      rsp_fz_ff   <= rsp_fz_in;
      rsp_e_ff    <= rsp_e_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Position memory
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wr_addr] <= pos_wr_data;
      end
      if (pos_re) begin
         pos_q_ff <= pos_mem[pos_rd_addr];
      end
   end

   // Force memory
   always_ff @(posedge clock) begin
      if (frc_we) begin
         frc_mem[frc_wr_addr] <= frc_wr_data;
      end
      if (frc_re) begin
         frc_q_ff <= frc_mem[frc_rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_atom_index   = rsp_idx_ff;
   assign rsp_force_x      = rsp_fx_ff;
   assign rsp_force_y      = rsp_fy_ff;
   assign rsp_force_z      = rsp_fz_ff;
   assign rsp_total_energy = rsp_e_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// File: hdl/ljpf_checker.sv
// Port checker for the Lennard-Jones pair force block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ljpf_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [ljpf_pkg::KIND_W-1:0]         req_kind,
   input wire logic [ljpf_pkg::ATOM_W-1:0]         req_atom_a,
   input wire logic [ljpf_pkg::ATOM_W-1:0]         req_atom_b,
   input wire logic signed [ljpf_pkg::COORD_W-1:0] req_coord_x,
   input wire logic signed [ljpf_pkg::COORD_W-1:0] req_coord_y,
   input wire logic signed [ljpf_pkg::COORD_W-1:0] req_coord_z,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [ljpf_pkg::ATOM_W-1:0]         rsp_atom_index,
   input wire logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_x,
   input wire logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_y,
   input wire logic signed [ljpf_pkg::ACC_W-1:0]   rsp_force_z,
   input wire logic signed [ljpf_pkg::ACC_W-1:0]   rsp_total_energy,
   input wire logic                                rsp_last,
   input wire logic                                csr_write_enable,
   input wire logic [ljpf_pkg::CSR_IX_W-1:0]       csr_index,
   input wire logic [ljpf_pkg::ACC_W-1:0]          csr_write_data
);

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays valid and its index, x and z forces hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_atom_index)
                                  && $stable(rsp_force_x) && $stable(rsp_force_z))
      else $error("stalled result changed");

   // while the sweep has results to go, no new item is taken
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("item taken during finish sweep");

   // a finish transfer starts the sweep
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == ljpf_pkg::KIND_FINISH |=> !req_ready)
      else $error("finish did not start sweep");

   // within one sweep the energy holds and atoms come in order
   a_sweep_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !rsp_valid
         || (rsp_total_energy == $past(rsp_total_energy)
             && rsp_atom_index == $past(rsp_atom_index) + 6'd1))
      else $error("sweep order or energy broken");

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (.*);

`default_nettype wire
